@@ sv/cmat_pkg.sv @@
package cmat_pkg;

    localparam int HALF_WINDOW_DEF = 5;
    localparam int HALF_WINDOW_MAX = 16;

    localparam int LAT_W   = 31;
    localparam int LON_W   = 32;
    localparam int STAMP_W = 40;

    // point count up to 2*HALF_WINDOW_MAX+1
    localparam int CNT_W = $clog2(2 * HALF_WINDOW_MAX + 2);

    localparam int LAT_SUM_W   = LAT_W + CNT_W;
    localparam int LON_SUM_W   = LON_W + CNT_W;
    localparam int STAMP_SUM_W = STAMP_W + CNT_W;

    localparam int DIV_W     = STAMP_SUM_W;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    localparam int HIST_W = LAT_W + LON_W + STAMP_W;

    typedef struct packed {
        logic signed [LAT_SUM_W-1:0] lat_sum;
        logic signed [LON_SUM_W-1:0] lon_sum;
        logic [STAMP_SUM_W-1:0]      stamp_sum;
        logic [CNT_W-1:0]            count;
        logic                        last;
    } job_t;

endpackage

@@ sv/cmat_queue.sv @@
module cmat_queue
    import cmat_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output job_t pop_job,
    output logic empty
);

    job_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;

    assign full    = (fill_reg == 2'd2);
    assign empty   = (fill_reg == 2'd0);
    assign pop_job = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

endmodule

@@ sv/cmat_front.sv @@
module cmat_front
    import cmat_pkg::*;
#(
    parameter int HALF_WINDOW = HALF_WINDOW_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [LAT_W-1:0]   lat,
    input  logic signed [LON_W-1:0]   lon,
    input  logic [STAMP_W-1:0]        stamp,
    input  logic                      end_of_track,
    output logic                      push,
    output job_t                      push_job,
    input  logic                      q_full
);

    localparam int SPAN = 2 * HALF_WINDOW + 1;
    localparam int PW   = $clog2(SPAN);
    localparam logic [CNT_W-1:0] SPAN_C = CNT_W'(SPAN);
    localparam logic [CNT_W-1:0] HW_C   = CNT_W'(HALF_WINDOW);

    localparam logic [2:0] F_IDLE  = 3'd0;
    localparam logic [2:0] F_ADD   = 3'd1;
    localparam logic [2:0] F_EMIT  = 3'd2;
    localparam logic [2:0] F_FLUSH = 3'd3;
    localparam logic [2:0] F_DROP  = 3'd4;

    logic [2:0] state_reg, state_next;

    logic [HIST_W-1:0] hist_mem [SPAN];
    logic [HIST_W-1:0] hist_rd_reg;

    logic signed [LAT_W-1:0] lat_in_reg;
    logic signed [LON_W-1:0] lon_in_reg;
    logic [STAMP_W-1:0]      stamp_in_reg;
    logic                    eot_reg;

    logic signed [LAT_SUM_W-1:0] lat_sum_reg, lat_sum_next;
    logic signed [LON_SUM_W-1:0] lon_sum_reg, lon_sum_next;
    logic [STAMP_SUM_W-1:0]      stamp_sum_reg, stamp_sum_next;
    logic [CNT_W-1:0]            points_reg, points_next;
    logic [CNT_W-1:0]            k_reg, k_next;
    logic [PW-1:0]               wr_ptr_reg, wr_ptr_next;

    logic [CNT_W-1:0] wr_ext;
    logic [CNT_W-1:0] old_idx;
    logic [PW-1:0]    old_addr;
    logic             full_win;

    logic signed [LAT_W-1:0] old_lat;
    logic signed [LON_W-1:0] old_lon;
    logic [STAMP_W-1:0]      old_stamp;

    logic signed [LAT_SUM_W-1:0] lat_sub, lat_add;
    logic signed [LON_SUM_W-1:0] lon_sub, lon_add;
    logic [STAMP_SUM_W-1:0]      stamp_sub, stamp_add;

    logic [CNT_W-1:0] need;

    // oldest held point sits points_reg slots behind the write pointer
    assign wr_ext   = CNT_W'(wr_ptr_reg);
    assign old_idx  = (wr_ext >= points_reg) ? (wr_ext - points_reg)
                                             : (wr_ext + SPAN_C - points_reg);
    assign old_addr = old_idx[PW-1:0];
    assign full_win = (points_reg == SPAN_C);

    assign old_lat   = hist_rd_reg[LAT_W-1:0];
    assign old_lon   = hist_rd_reg[LAT_W+LON_W-1:LAT_W];
    assign old_stamp = hist_rd_reg[HIST_W-1:LAT_W+LON_W];

    assign lat_sub   = {{(LAT_SUM_W-LAT_W){old_lat[LAT_W-1]}}, old_lat};
    assign lon_sub   = {{(LON_SUM_W-LON_W){old_lon[LON_W-1]}}, old_lon};
    assign stamp_sub = {{(STAMP_SUM_W-STAMP_W){1'b0}}, old_stamp};
    assign lat_add   = {{(LAT_SUM_W-LAT_W){lat_in_reg[LAT_W-1]}}, lat_in_reg};
    assign lon_add   = {{(LON_SUM_W-LON_W){lon_in_reg[LON_W-1]}}, lon_in_reg};
    assign stamp_add = {{(STAMP_SUM_W-STAMP_W){1'b0}}, stamp_in_reg};

    assign need     = HW_C + k_reg;
    assign in_ready = (state_reg == F_IDLE);

    assign push_job.lat_sum   = lat_sum_reg;
    assign push_job.lon_sum   = lon_sum_reg;
    assign push_job.stamp_sum = stamp_sum_reg;
    assign push_job.count     = points_reg;
    assign push_job.last      = (state_reg == F_FLUSH) && (k_reg == CNT_W'(1));

    always_comb
    begin
        state_next     = state_reg;
        lat_sum_next   = lat_sum_reg;
        lon_sum_next   = lon_sum_reg;
        stamp_sum_next = stamp_sum_reg;
        points_next    = points_reg;
        k_next         = k_reg;
        wr_ptr_next    = wr_ptr_reg;
        push           = 1'b0;
        unique case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = F_ADD;
                end
            end
            F_ADD:
            begin
                lat_sum_next   = lat_sum_reg - (full_win ? lat_sub : '0) + lat_add;
                lon_sum_next   = lon_sum_reg - (full_win ? lon_sub : '0) + lon_add;
                stamp_sum_next = stamp_sum_reg - (full_win ? stamp_sub : '0) + stamp_add;
                points_next    = full_win ? points_reg : points_reg + CNT_W'(1);
                wr_ptr_next    = (wr_ptr_reg == PW'(SPAN - 1)) ? '0 : wr_ptr_reg + PW'(1);
                if (points_next > HW_C)
                begin
                    state_next = F_EMIT;
                end
                else if (eot_reg)
                begin
                    k_next     = points_next;
                    state_next = F_FLUSH;
                end
                else
                begin
                    state_next = F_IDLE;
                end
            end
            F_EMIT:
            begin
                if (!q_full)
                begin
                    push = 1'b1;
                    if (eot_reg)
                    begin
                        k_next     = (points_reg < HW_C) ? points_reg : HW_C;
                        state_next = F_FLUSH;
                    end
                    else
                    begin
                        state_next = F_IDLE;
                    end
                end
            end
            F_FLUSH:
            begin
                if (points_reg > need)
                begin
                    state_next = F_DROP;
                end
                else if (!q_full)
                begin
                    push = 1'b1;
                    if (k_reg == CNT_W'(1))
                    begin
                        lat_sum_next   = '0;
                        lon_sum_next   = '0;
                        stamp_sum_next = '0;
                        points_next    = '0;
                        state_next     = F_IDLE;
                    end
                    else
                    begin
                        k_next = k_reg - CNT_W'(1);
                    end
                end
            end
            F_DROP:
            begin
                lat_sum_next   = lat_sum_reg - lat_sub;
                lon_sum_next   = lon_sum_reg - lon_sub;
                stamp_sum_next = stamp_sum_reg - stamp_sub;
                points_next    = points_reg - CNT_W'(1);
                state_next     = F_FLUSH;
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        hist_rd_reg <= hist_mem[old_addr];
        if (state_reg == F_ADD)
        begin
            hist_mem[wr_ptr_reg] <= {stamp_in_reg, lon_in_reg, lat_in_reg};
        end
        if (in_valid && in_ready)
        begin
            lat_in_reg   <= lat;
            lon_in_reg   <= lon;
            stamp_in_reg <= stamp;
            eot_reg      <= end_of_track;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= F_IDLE;
            lat_sum_reg   <= '0;
            lon_sum_reg   <= '0;
            stamp_sum_reg <= '0;
            points_reg    <= '0;
            k_reg         <= '0;
            wr_ptr_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            lat_sum_reg   <= lat_sum_next;
            lon_sum_reg   <= lon_sum_next;
            stamp_sum_reg <= stamp_sum_next;
            points_reg    <= points_next;
            k_reg         <= k_next;
            wr_ptr_reg    <= wr_ptr_next;
        end
    end

endmodule

@@ sv/cmat_back.sv @@
module cmat_back
    import cmat_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_empty,
    input  job_t                    pop_job,
    output logic                    pop,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [LAT_W-1:0] avg_lat,
    output logic signed [LON_W-1:0] avg_lon,
    output logic [STAMP_W-1:0]      avg_stamp,
    output logic                    last_of_track
);

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_LOAD = 2'd1;
    localparam logic [1:0] B_DIV  = 2'd2;
    localparam logic [1:0] B_DONE = 2'd3;

    localparam logic [1:0] SEL_LAT   = 2'd0;
    localparam logic [1:0] SEL_LON   = 2'd1;
    localparam logic [1:0] SEL_STAMP = 2'd2;

    logic [1:0]           state_reg;
    logic [1:0]           sel_reg;
    job_t                 job_reg;
    logic [DIV_W-1:0]     div_reg;
    logic [CNT_W-1:0]     rem_reg;
    logic [DIV_CNT_W-1:0] step_reg;
    logic                 neg_reg;

    logic signed [LAT_W-1:0] res_lat_reg;
    logic signed [LON_W-1:0] res_lon_reg;

    logic signed [LAT_W-1:0] out_lat_reg;
    logic signed [LON_W-1:0] out_lon_reg;
    logic [STAMP_W-1:0]      out_stamp_reg;
    logic                    out_last_reg;
    logic                    out_valid_reg;

    logic [LAT_SUM_W-1:0] lat_mag;
    logic [LON_SUM_W-1:0] lon_mag;
    logic [DIV_W-1:0]     mag;
    logic                 mag_neg;
    logic [CNT_W:0]       rem_try;
    logic                 q_bit;
    logic [DIV_W-1:0]     quot;
    logic [DIV_W-1:0]     quot_signed;
    logic                 out_free;

    assign lat_mag = job_reg.lat_sum[LAT_SUM_W-1] ? LAT_SUM_W'(-job_reg.lat_sum)
                                                 : LAT_SUM_W'(job_reg.lat_sum);
    assign lon_mag = job_reg.lon_sum[LON_SUM_W-1] ? LON_SUM_W'(-job_reg.lon_sum)
                                                 : LON_SUM_W'(job_reg.lon_sum);

    always_comb
    begin
        unique case (sel_reg)
            SEL_LAT:
            begin
                mag     = DIV_W'(lat_mag);
                mag_neg = job_reg.lat_sum[LAT_SUM_W-1];
            end
            SEL_LON:
            begin
                mag     = DIV_W'(lon_mag);
                mag_neg = job_reg.lon_sum[LON_SUM_W-1];
            end
            default:
            begin
                mag     = job_reg.stamp_sum;
                mag_neg = 1'b0;
            end
        endcase
    end

    // restoring division, one quotient bit per cycle
    assign rem_try     = {rem_reg, div_reg[DIV_W-1]};
    assign q_bit       = (rem_try >= {1'b0, job_reg.count});
    assign quot        = {div_reg[DIV_W-2:0], q_bit};
    assign quot_signed = neg_reg ? -quot : quot;

    assign out_free = !out_valid_reg || out_ready;
    assign pop      = (state_reg == B_IDLE) && !q_empty;

    assign out_valid     = out_valid_reg;
    assign avg_lat       = out_lat_reg;
    assign avg_lon       = out_lon_reg;
    assign avg_stamp     = out_stamp_reg;
    assign last_of_track = out_last_reg;

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    job_reg <= pop_job;
                end
            end
            B_LOAD:
            begin
                div_reg  <= mag + DIV_W'(job_reg.count >> 1);
                neg_reg  <= mag_neg;
                rem_reg  <= '0;
                step_reg <= '0;
            end
            B_DIV:
            begin
                div_reg  <= quot;
                rem_reg  <= q_bit ? CNT_W'(rem_try - {1'b0, job_reg.count})
                                  : CNT_W'(rem_try);
                step_reg <= step_reg + DIV_CNT_W'(1);
                if (step_reg == DIV_CNT_W'(DIV_W - 1))
                begin
                    if (sel_reg == SEL_LAT)
                    begin
                        res_lat_reg <= quot_signed[LAT_W-1:0];
                    end
                    if (sel_reg == SEL_LON)
                    begin
                        res_lon_reg <= quot_signed[LON_W-1:0];
                    end
                end
            end
            B_DONE:
            begin
                if (out_free)
                begin
                    out_lat_reg   <= res_lat_reg;
                    out_lon_reg   <= res_lon_reg;
                    out_stamp_reg <= div_reg[STAMP_W-1:0];
                    out_last_reg  <= job_reg.last;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            sel_reg       <= SEL_LAT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if ((state_reg == B_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                B_IDLE:
                begin
                    if (!q_empty)
                    begin
                        sel_reg   <= SEL_LAT;
                        state_reg <= B_LOAD;
                    end
                end
                B_LOAD:
                begin
                    state_reg <= B_DIV;
                end
                B_DIV:
                begin
                    if (step_reg == DIV_CNT_W'(DIV_W - 1))
                    begin
                        if (sel_reg == SEL_STAMP)
                        begin
                            state_reg <= B_DONE;
                        end
                        else
                        begin
                            sel_reg   <= sel_reg + 2'd1;
                            state_reg <= B_LOAD;
                        end
                    end
                end
                B_DONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

endmodule

@@ sv/centered_moving_average_track.sv @@
// Centered moving average of a track with the window clipped at both ends.
// Each accepted point passes through the front's add state (and its emit
// state when it yields a result) before the front takes a new point; an end
// mark adds a flush step, and any drop steps needed, per flushed result.
// Every result then runs through one shared restoring divider, one quotient
// bit per cycle for latitude, longitude and time in turn; that divider sets
// the sustained rate. A two-entry queue of window sums sits between the
// front and the divider. Results lag the input by HALF_WINDOW points; the
// end mark flushes the rest of the track with tlast on its final result.
module centered_moving_average_track
    import cmat_pkg::*;
#(
    parameter int HALF_WINDOW = HALF_WINDOW_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,   // lat[30:0], lon[62:31], stamp[102:63], zero pad
    input  logic         s_tlast,   // end_of_track
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // avg_lat[30:0], avg_lon[62:31], avg_stamp[102:63], pad
    output logic         m_tlast    // last_of_track
);

    logic push;
    logic pop;
    logic q_full;
    logic q_empty;
    job_t push_job;
    job_t pop_job;

    logic signed [LAT_W-1:0] avg_lat;
    logic signed [LON_W-1:0] avg_lon;
    logic [STAMP_W-1:0]      avg_stamp;

    cmat_front #(
        .HALF_WINDOW(HALF_WINDOW)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .lat         (s_tdata[LAT_W-1:0]),
        .lon         (s_tdata[LAT_W+LON_W-1:LAT_W]),
        .stamp       (s_tdata[HIST_W-1:LAT_W+LON_W]),
        .end_of_track(s_tlast),
        .push        (push),
        .push_job    (push_job),
        .q_full      (q_full)
    );

    cmat_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_job(push_job),
        .full    (q_full),
        .pop     (pop),
        .pop_job (pop_job),
        .empty   (q_empty)
    );

    cmat_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .pop_job      (pop_job),
        .pop          (pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .avg_lat      (avg_lat),
        .avg_lon      (avg_lon),
        .avg_stamp    (avg_stamp),
        .last_of_track(m_tlast)
    );

    assign m_tdata = {1'b0, avg_stamp, avg_lon, avg_lat};

endmodule

@@ verif/tb_centered_moving_average_track.sv @@
module tb_centered_moving_average_track;
    import cmat_pkg::*;

    localparam int HW   = HALF_WINDOW_DEF;
    localparam int SPAN = 2 * HW + 1;

    typedef struct packed {
        logic [STAMP_W-1:0] stamp;
        logic [LON_W-1:0]   lon;
        logic [LAT_W-1:0]   lat;
        logic               eot;
    } point_t;

    typedef struct packed {
        logic [LAT_W-1:0]   lat;
        logic [LON_W-1:0]   lon;
        logic [STAMP_W-1:0] stamp;
        logic               last;
    } smooth_t;

    logic         clk = 1'b0;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [103:0] s_tdata;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [103:0] m_tdata;
    logic         m_tlast;

    centered_moving_average_track i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    point_t  pending_points[$];
    smooth_t expected_points[$];
    int      error_count = 0;
    int      send_idle_pct = 13;
    int      recv_idle_pct = 63;
    bit      hold_send = 0;

    // track window, index 0 newest
    longint  win_lat[SPAN];
    longint  win_lon[SPAN];
    longint  win_stamp[SPAN];
    longint  sum_lat, sum_lon, sum_stamp;
    int      held;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint round_mean(longint s, int n);
        longint h;
        h = n / 2;
        if (s >= 0)
            return (s + h) / n;
        return -((-s + h) / n);
    endfunction

    function automatic void drop_oldest();
        held--;
        sum_lat   -= win_lat[held];
        sum_lon   -= win_lon[held];
        sum_stamp -= win_stamp[held];
    endfunction

    function automatic void push_mean(bit last);
        smooth_t r;
        r.lat   = LAT_W'(round_mean(sum_lat, held));
        r.lon   = LON_W'(round_mean(sum_lon, held));
        r.stamp = STAMP_W'(round_mean(sum_stamp, held));
        r.last  = last;
        expected_points = {expected_points, r};
    endfunction

    function automatic void predict_smoothing(point_t p);
        int first;
        if (held >= SPAN)
            drop_oldest();
        for (int k = SPAN - 1; k > 0; k--)
        begin
            win_lat[k]   = win_lat[k-1];
            win_lon[k]   = win_lon[k-1];
            win_stamp[k] = win_stamp[k-1];
        end
        win_lat[0]   = longint'($signed(p.lat));
        win_lon[0]   = longint'($signed(p.lon));
        win_stamp[0] = longint'({24'd0, p.stamp});
        sum_lat   += win_lat[0];
        sum_lon   += win_lon[0];
        sum_stamp += win_stamp[0];
        held++;
        if (held > HW)
            push_mean(0);
        if (p.eot)
        begin
            first = held < HW ? held : HW;
            for (int k = first; k > 0; k--)
            begin
                while (held > HW + k)
                    drop_oldest();
                push_mean(k == 1);
            end
            sum_lat = 0;
            sum_lon = 0;
            sum_stamp = 0;
            held = 0;
        end
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
        error_count++;
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 0;
            s_tdata  <= '0;
            s_tlast  <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predict_smoothing({s_tdata[102:63], s_tdata[62:31], s_tdata[30:0], s_tlast});
            if (!s_tvalid || s_tready)
            begin
                if (pending_points.size() > 0 && !hold_send &&
                    $urandom_range(99) >= send_idle_pct)
                begin
                    point_t p;
                    p = pending_points.pop_front();
                    s_tvalid <= 1;
                    s_tdata  <= {1'b0, p.stamp, p.lon, p.lat};
                    s_tlast  <= p.eot;
                end
                else
                    s_tvalid <= 0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_points.size() == 0)
                begin
                    report_mismatch("unexpected item", 1, 0);
                end
                else
                begin
                    smooth_t e;
                    e = expected_points.pop_front();
                    if (m_tdata[30:0] !== e.lat)
                        report_mismatch("avg_lat", $signed(m_tdata[30:0]), $signed(e.lat));
                    if (m_tdata[62:31] !== e.lon)
                        report_mismatch("avg_lon", $signed(m_tdata[62:31]), $signed(e.lon));
                    if (m_tdata[102:63] !== e.stamp)
                        report_mismatch("avg_stamp", m_tdata[102:63], e.stamp);
                    if (m_tlast !== e.last)
                        report_mismatch("last_of_track", m_tlast, e.last);
                end
            end
            m_tready <= $urandom_range(99) >= recv_idle_pct;
        end
    end

    function automatic point_t rand_point(bit eot);
        point_t p;
        p.lat   = LAT_W'($urandom_range(1800000000) - 900000000);
        p.lon   = LON_W'(longint'($urandom_range(3600000)) * 1000 - 1800000000
                  + $urandom_range(999));
        p.stamp = {8'($urandom_range(255)), $urandom()};
        p.eot   = eot;
        return p;
    endfunction

    function automatic point_t make_point(longint la, longint lo, longint st, bit eot);
        point_t p;
        p.lat = LAT_W'(la);
        p.lon = LON_W'(lo);
        p.stamp = STAMP_W'(st);
        p.eot = eot;
        return p;
    endfunction

    function automatic void queue_point(point_t p);
        pending_points = {pending_points, p};
    endfunction

    function automatic void queue_track(int len);
        for (int i = 0; i < len; i++)
            queue_point(rand_point(i == len - 1));
    endfunction

    task automatic drain();
        while (pending_points.size() > 0 || s_tvalid || expected_points.size() > 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    initial begin
        int sent;
        int len;
        held = 0;
        sum_lat = 0;
        sum_lon = 0;
        sum_stamp = 0;
        rst_n = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1;

        // extremes and ties; single point track, short tracks, span plus two
        queue_point(make_point(900000000, 2147483647 - 347483647,
                               64'hFF_FFFF_FFFF, 1));
        queue_point(make_point(-900000000, -1800000000, 0, 0));
        queue_point(make_point(-899999999, 1800000000, 1, 1));
        queue_point(make_point(-1, -1, 0, 0));
        queue_point(make_point(0, 0, 0, 0));
        queue_point(make_point(-2, 3, 2, 1));
        for (int i = 0; i < SPAN + 2; i++)
            queue_point(make_point(i[0] ? 900000000 : -900000000,
                                   i[0] ? -1800000000 : 1800000000,
                                   i[0] ? 64'hFF_FFFF_FFFF : 0,
                                   i == SPAN + 1));
        queue_track(HW);
        drain();

        sent = 0;
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = ph == 0 ? 13 : (ph == 1 ? 63 : 0);
            recv_idle_pct = ph == 0 ? 63 : (ph == 1 ? 13 : 0);
            while (sent < (ph + 1) * 160)
            begin
                case ($urandom_range(3))
                    0: len = $urandom_range(1, HW);
                    1: len = $urandom_range(HW + 1, SPAN + 1);
                    default: len = $urandom_range(1, 40);
                endcase
                queue_track(len);
                sent += len;
            end
            while (pending_points.size() > 0 || s_tvalid)
                @(posedge clk);
            if (ph == 0)
            begin
                // sender holds off until everything is out
                hold_send = 1;
                while (expected_points.size() > 0)
                    @(posedge clk);
                hold_send = 0;
            end
        end
        drain();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #20000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
